// ===== rtl/deque_with_min_max_tracking_unit_macros.svh =====
// Assertion helpers, clocked on clock and held off during reset.
`ifndef DEQUE_WITH_MIN_MAX_TRACKING_UNIT_MACROS_SVH
`define DEQUE_WITH_MIN_MAX_TRACKING_UNIT_MACROS_SVH

`ifndef SYNTH
`define DMM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("deque unit check failed");
`define DMM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque unit check failed");
`else
`define DMM_ASSERT(lbl, prop)
`define DMM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dmm_pkg.sv =====
`default_nettype none

package dmm_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int KIND_BITS   = 3;
   localparam int POS_BITS    = 6;
   localparam int STATUS_BITS = 2;

   // stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = ((VALUE_BITS + POS_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((3 * VALUE_BITS + CNT_BITS + 7) / 8) * 8;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   localparam value_type MIN_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type MAX_RESET = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_OVERWRITE  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } fsm_state_type;

   // per-cycle command to the cell ring
   typedef struct packed {
      logic                push_front; // every cell takes its lower neighbor, cell 0 the write data
      logic                rotate;     // every cell takes its upper neighbor, wraps
      logic                wr;         // write one cell
      logic [IDX_BITS-1:0] wr_idx;
   } ring_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/dmm_cell.sv =====
`default_nettype none

module dmm_cell (
   input  wire logic                 clock,
   input  wire dmm_pkg::ring_ctl_type ctl,
   input  wire logic                 wr_en,
   input  wire dmm_pkg::value_type   wr_data,
   input  wire dmm_pkg::value_type   left_val,
   input  wire dmm_pkg::value_type   right_val,
   output dmm_pkg::value_type        value
);

   dmm_pkg::value_type value_ff;
   dmm_pkg::value_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push_front) begin
         value_in = left_val;
      end else if (ctl.rotate) begin
         value_in = right_val;
      end else if (wr_en) begin
         value_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/dmm_chain.sv =====
`default_nettype none

// Ring of cells; cell 0 always holds the front entry outside a scan.
module dmm_chain (
   input  wire logic                  clock,
   input  wire dmm_pkg::ring_ctl_type ctl,
   input  wire dmm_pkg::value_type    wr_data,
   output dmm_pkg::value_type         head
);

   dmm_pkg::value_type vals [dmm_pkg::CAPACITY];

   for (genvar i = 0; i < dmm_pkg::CAPACITY; i++) begin : g_cell
      dmm_pkg::value_type left_val;
      dmm_pkg::value_type right_val;
      logic               wr_en;

      if (i == 0) begin : g_first
         assign left_val = wr_data;
      end else begin : g_mid
         assign left_val = vals[i-1];
      end

      if (i == dmm_pkg::CAPACITY - 1) begin : g_last
         assign right_val = vals[0];
      end else begin : g_inner
         assign right_val = vals[i+1];
      end

      assign wr_en = ctl.wr && (ctl.wr_idx == dmm_pkg::IDX_BITS'(i));

      dmm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wr_en     (wr_en),
         .wr_data   (wr_data),
         .left_val  (left_val),
         .right_val (right_val),
         .value     (vals[i])
      );
   end

   assign head = vals[0];

endmodule

`default_nettype wire

// ===== rtl/deque_with_min_max_tracking_unit.sv =====
`default_nettype none

// Bounded double-ended queue of signed values with a running minimum and
// maximum. Entries live in a ring of cells with the front always in cell 0:
// push front shifts the whole row up by one, pop front rotates it down, push
// back and overwrite write one cell. Each accepted transfer gives exactly one
// response transfer carrying status, the popped value (zero if none), the new
// count and the tracked extremes. Push, overwrite, failed operations and a pop
// that empties the deque answer from the response register in the cycle after
// the request transfer. Any other pop first scans the ring, which rotates one
// full turn, one cell per cycle, so that cell 0 sees every entry; that pass
// recovers the back entry on pop back and recomputes the minimum and maximum.
// Only the extreme that the removed value matched is replaced. Overwrite
// leaves the extremes alone, so they may go stale. A new request is taken
// only between operations, while the response register is empty or being
// drained in the same cycle.
module deque_with_min_max_tracking_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] value, [37:32] position, rest zero
   input  wire logic [dmm_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [2:0] kind
   input  wire logic [dmm_pkg::KIND_BITS-1:0]     req_tuser,

   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] removed_value, [38:32] count, [70:39] min_value,
   // [102:71] max_value, rest zero
   output logic [dmm_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // [1:0] status
   output logic [dmm_pkg::STATUS_BITS-1:0]        rsp_tuser
);

   `include "deque_with_min_max_tracking_unit_macros.svh"

   localparam int IW = dmm_pkg::IDX_BITS;
   localparam int CW = dmm_pkg::CNT_BITS;
   localparam logic [IW-1:0] K_LAST = IW'(dmm_pkg::CAPACITY - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(dmm_pkg::CAPACITY);

   // request fields
   dmm_pkg::kind_type  req_kind;
   dmm_pkg::value_type req_value;
   logic [dmm_pkg::POS_BITS-1:0] req_pos;

   assign req_kind  = dmm_pkg::kind_type'(req_tuser);
   assign req_value = $signed(req_tdata[dmm_pkg::VALUE_BITS-1:0]);
   assign req_pos   = req_tdata[dmm_pkg::VALUE_BITS +: dmm_pkg::POS_BITS];

   // control and tracking state
   dmm_pkg::fsm_state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   dmm_pkg::value_type min_ff, min_in;
   dmm_pkg::value_type max_ff, max_in;
   logic [IW-1:0]      k_ff, k_in;          // scan step
   dmm_pkg::value_type lo_ff, lo_in;        // scan partial minimum
   dmm_pkg::value_type hi_ff, hi_in;        // scan partial maximum
   dmm_pkg::value_type removed_ff, removed_in;
   logic               pop_back_ff, pop_back_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   dmm_pkg::status_type rsp_status_ff, rsp_status_in;
   dmm_pkg::value_type rsp_removed_ff, rsp_removed_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   dmm_pkg::value_type rsp_min_ff, rsp_min_in;
   dmm_pkg::value_type rsp_max_ff, rsp_max_in;

   dmm_pkg::ring_ctl_type ring_ctl;
   dmm_pkg::value_type    head;

   dmm_chain u_chain (
      .clock   (clock),
      .ctl     (ring_ctl),
      .wr_data (req_value),
      .head    (head)
   );

   // scan step helpers
   logic               k_in_range;
   logic               k_at_back;
   dmm_pkg::value_type lo_nx, hi_nx, removed_nx;

   always_comb begin
      k_in_range = CW'(k_ff) < count_ff;
      k_at_back  = pop_back_ff && (CW'(k_ff) == count_ff);
      lo_nx      = (k_in_range && (head < lo_ff)) ? head : lo_ff;
      hi_nx      = (k_in_range && (head > hi_ff)) ? head : hi_ff;
      removed_nx = k_at_back ? head : removed_ff;
   end

   logic               respond;
   dmm_pkg::status_type status_now;
   dmm_pkg::value_type removed_now;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      removed_in   = removed_ff;
      pop_back_in  = pop_back_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_max_in     = rsp_max_ff;
      ring_ctl     = '0;
      req_tready   = 1'b0;
      respond      = 1'b0;
      status_now   = dmm_pkg::STATUS_OK;
      removed_now  = '0;

      unique case (state_ff)
         dmm_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               respond = 1'b1;
               k_in    = '0;
               lo_in   = dmm_pkg::MIN_RESET;
               hi_in   = dmm_pkg::MAX_RESET;
               case (req_kind) inside
                  dmm_pkg::KIND_PUSH_FRONT, dmm_pkg::KIND_PUSH_BACK: begin
                     if (count_ff == CNT_FULL) begin
                        status_now = dmm_pkg::STATUS_FULL;
                     end else begin
                        ring_ctl.push_front = (req_kind == dmm_pkg::KIND_PUSH_FRONT);
                        ring_ctl.wr         = (req_kind == dmm_pkg::KIND_PUSH_BACK);
                        ring_ctl.wr_idx     = count_ff[IW-1:0];
                        count_in = CW'(count_ff + 1'b1);
                        if (req_value > max_ff) begin
                           max_in = req_value;
                        end
                        if (req_value < min_ff) begin
                           min_in = req_value;
                        end
                     end
                  end
                  dmm_pkg::KIND_POP_FRONT, dmm_pkg::KIND_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_now = dmm_pkg::STATUS_EMPTY;
                     end else begin
                        count_in    = CW'(count_ff - 1'b1);
                        pop_back_in = (req_kind == dmm_pkg::KIND_POP_BACK);
                        // front pop: drop cell 0 now, scan the rest later
                        ring_ctl.rotate = (req_kind == dmm_pkg::KIND_POP_FRONT);
                        removed_in      = head;
                        if (count_ff == CW'(1)) begin
                           // last entry leaves; it sits in cell 0 either way
                           removed_now = head;
                           min_in      = dmm_pkg::MIN_RESET;
                           max_in      = dmm_pkg::MAX_RESET;
                        end else begin
                           respond  = 1'b0;
                           state_in = dmm_pkg::ST_SCAN;
                        end
                     end
                  end
                  dmm_pkg::KIND_OVERWRITE: begin
                     if (32'(req_pos) >= 32'(count_ff)) begin
                        status_now = dmm_pkg::STATUS_RANGE;
                     end else begin
                        ring_ctl.wr     = 1'b1;
                        ring_ctl.wr_idx = IW'(req_pos);
                     end
                  end
                  default: begin
                     // unused kinds: no change
                  end
               endcase
               if (respond) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = status_now;
                  rsp_removed_in = removed_now;
                  rsp_count_in   = count_in;
                  rsp_min_in     = min_in;
                  rsp_max_in     = max_in;
               end
            end
         end
         dmm_pkg::ST_SCAN: begin
            // one full turn: cell 0 shows entry k at step k
            ring_ctl.rotate = 1'b1;
            lo_in      = lo_nx;
            hi_in      = hi_nx;
            removed_in = removed_nx;
            k_in       = IW'(k_ff + 1'b1);
            if (k_ff == K_LAST) begin
               k_in     = '0;
               state_in = dmm_pkg::ST_IDLE;
               if (removed_nx == min_ff) begin
                  min_in = lo_nx;
               end
               if (removed_nx == max_ff) begin
                  max_in = hi_nx;
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = dmm_pkg::STATUS_OK;
               rsp_removed_in = removed_nx;
               rsp_count_in   = count_ff;
               rsp_min_in     = min_in;
               rsp_max_in     = max_in;
            end
         end
         default: begin
            state_in = dmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmm_pkg::ST_IDLE;
         count_ff     <= '0;
         min_ff       <= dmm_pkg::MIN_RESET;
         max_ff       <= dmm_pkg::MAX_RESET;
         k_ff         <= '0;
         pop_back_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         k_ff         <= k_in;
         pop_back_ff  <= pop_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_max_ff     <= rsp_max_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = dmm_pkg::RSP_DATA_BITS'({rsp_max_ff, rsp_min_ff,
                                                rsp_count_ff, rsp_removed_ff});

   // fill level never passes the ring size
   `DMM_ASSERT(a_count_bound, count_ff <= CNT_FULL)
   // a scan only runs with the response register drained
   `DMM_ASSERT(a_scan_no_rsp, (state_ff != dmm_pkg::ST_SCAN) || !rsp_valid_ff)
   // the fill level holds through a scan
   `DMM_ASSERT_NEXT(a_scan_count, state_ff == dmm_pkg::ST_SCAN, $stable(count_ff))
   // empty deque always carries the reset extremes
   `DMM_ASSERT(a_empty_extremes, (count_ff != '0) ||
      ((min_ff == dmm_pkg::MIN_RESET) && (max_ff == dmm_pkg::MAX_RESET)))

endmodule

`default_nettype wire

// ===== dv/tb_deque_with_min_max_tracking_unit.sv =====
`timescale 1ns / 100ps

module tb_deque_with_min_max_tracking_unit;

   // kinds with no operation behind them; the block must answer STATUS_OK
   localparam logic [dmm_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [dmm_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

   localparam int RANDOM_PER_PHASE = 333;
   localparam int NUM_PHASES       = 4;
   // a rescanning pop runs with no transfer on either side
   localparam int QUIET_LIMIT      = 5000;

   // idle odds per phase, in percent: none, sender, receiver, both
   int unsigned sender_idle_pct [NUM_PHASES] = '{0, 63, 0, 20};
   int unsigned sink_stall_pct  [NUM_PHASES] = '{0, 0, 63, 20};

   typedef struct {
      logic [dmm_pkg::KIND_BITS-1:0] kind;
      dmm_pkg::value_type            value;
      logic [dmm_pkg::POS_BITS-1:0]  position;
      int unsigned                   phase;
   } deque_op_type;

   typedef struct {
      dmm_pkg::status_type           status;
      dmm_pkg::value_type            removed;
      logic [dmm_pkg::CNT_BITS-1:0]  count;
      dmm_pkg::value_type            low;
      dmm_pkg::value_type            high;
   } deque_reply_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [dmm_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [dmm_pkg::KIND_BITS-1:0]     req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [dmm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [dmm_pkg::STATUS_BITS-1:0]   rsp_tuser;

   deque_op_type    op_backlog[$];      // ops not yet offered
   deque_reply_type reply_backlog[$];   // predicted replies, oldest first
   deque_op_type    in_flight;
   int unsigned     ops_queued   = 0;
   int unsigned     ops_taken    = 0;
   int unsigned     run_phase    = 0;
   int unsigned     plan_fill    = 0;   // occupancy as seen by the stimulus planner
   int unsigned     quiet_cycles = 0;
   int unsigned     errors       = 0;

   // shadow deque: ring plus tracked extremes
   dmm_pkg::value_type shadow_ring[dmm_pkg::CAPACITY];
   int unsigned        shadow_head = 0;
   int unsigned        shadow_fill = 0;
   dmm_pkg::value_type low_mark    = dmm_pkg::MIN_RESET;
   dmm_pkg::value_type high_mark   = dmm_pkg::MAX_RESET;

   always #1 clock = ~clock;

   deque_with_min_max_tracking_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Advance the shadow deque by one op and produce the reply it should give.
   // A pop rescans only for the extreme the removed value matched, so stale
   // extremes left by an overwrite survive exactly as in the block.
   task automatic apply_deque_op(input deque_op_type op, output deque_reply_type rep);
      dmm_pkg::value_type popped;
      dmm_pkg::value_type lo;
      dmm_pkg::value_type hi;
      dmm_pkg::value_type v;
      int unsigned        k;
      popped     = '0;
      rep.status = dmm_pkg::STATUS_OK;
      case (op.kind)
         dmm_pkg::KIND_PUSH_FRONT, dmm_pkg::KIND_PUSH_BACK: begin
            if (shadow_fill == dmm_pkg::CAPACITY) begin
               rep.status = dmm_pkg::STATUS_FULL;
            end else begin
               if (op.kind == dmm_pkg::KIND_PUSH_FRONT) begin
                  shadow_head = (shadow_head + dmm_pkg::CAPACITY - 1) % dmm_pkg::CAPACITY;
                  shadow_ring[shadow_head] = op.value;
               end else begin
                  shadow_ring[(shadow_head + shadow_fill) % dmm_pkg::CAPACITY] = op.value;
               end
               shadow_fill++;
               if (op.value > high_mark) high_mark = op.value;
               if (op.value < low_mark) low_mark = op.value;
            end
         end
         dmm_pkg::KIND_POP_FRONT, dmm_pkg::KIND_POP_BACK: begin
            if (shadow_fill == 0) begin
               rep.status = dmm_pkg::STATUS_EMPTY;
            end else begin
               if (op.kind == dmm_pkg::KIND_POP_FRONT) begin
                  popped = shadow_ring[shadow_head];
                  shadow_head = (shadow_head + 1) % dmm_pkg::CAPACITY;
               end else begin
                  popped = shadow_ring[(shadow_head + shadow_fill - 1) % dmm_pkg::CAPACITY];
               end
               shadow_fill--;
               if (shadow_fill == 0) begin
                  low_mark  = dmm_pkg::MIN_RESET;
                  high_mark = dmm_pkg::MAX_RESET;
               end else begin
                  lo = dmm_pkg::MIN_RESET;
                  hi = dmm_pkg::MAX_RESET;
                  for (k = 0; k < shadow_fill; k++) begin
                     v = shadow_ring[(shadow_head + k) % dmm_pkg::CAPACITY];
                     if (v < lo) lo = v;
                     if (v > hi) hi = v;
                  end
                  if (popped == low_mark) low_mark = lo;
                  if (popped == high_mark) high_mark = hi;
               end
            end
         end
         dmm_pkg::KIND_OVERWRITE: begin
            if (op.position >= shadow_fill)
               rep.status = dmm_pkg::STATUS_RANGE;
            else
               shadow_ring[(shadow_head + op.position) % dmm_pkg::CAPACITY] = op.value;
         end
         default: ;   // spare kinds: no change
      endcase
      rep.removed = popped;
      rep.count   = dmm_pkg::CNT_BITS'(shadow_fill);
      rep.low     = low_mark;
      rep.high    = high_mark;
   endtask

   // Queue one op and keep the planner's occupancy in step.
   task automatic queue_op(input logic [dmm_pkg::KIND_BITS-1:0] kind,
                           input dmm_pkg::value_type value,
                           input logic [dmm_pkg::POS_BITS-1:0] position,
                           input int unsigned phase);
      deque_op_type op;
      op.kind     = kind;
      op.value    = value;
      op.position = position;
      op.phase    = phase;
      op_backlog.push_back(op);
      ops_queued++;
      case (kind)
         dmm_pkg::KIND_PUSH_FRONT, dmm_pkg::KIND_PUSH_BACK:
            if (plan_fill < dmm_pkg::CAPACITY) plan_fill++;
         dmm_pkg::KIND_POP_FRONT, dmm_pkg::KIND_POP_BACK:
            if (plan_fill > 0) plan_fill--;
         default: ;
      endcase
   endtask

   // Extremes and a narrow band (so duplicates of the extremes are common)
   // mixed with full-range values.
   function automatic dmm_pkg::value_type pick_value();
      case ($urandom_range(9))
         0:       return dmm_pkg::MIN_RESET;
         1:       return dmm_pkg::MAX_RESET;
         2, 3, 4: return dmm_pkg::value_type'(int'($urandom_range(16)) - 8);
         default: return dmm_pkg::value_type'($urandom);
      endcase
   endfunction

   // Stimulus plan and end of run.
   initial begin : stimulus
      int unsigned ph;
      int unsigned n;
      int unsigned roll;
      bit          filling;
      logic [dmm_pkg::POS_BITS-1:0] pos;

      // directed: empty-side errors, spare kind, extreme values, range check,
      // overwrites, duplicate extremes, drain to empty
      queue_op(dmm_pkg::KIND_POP_FRONT, '0, '0, 0);
      queue_op(dmm_pkg::KIND_POP_BACK, '0, '0, 0);
      queue_op(dmm_pkg::KIND_OVERWRITE, 123, '1, 0);
      queue_op(KIND_SPARE_HI, -1, '1, 0);
      queue_op(dmm_pkg::KIND_PUSH_BACK, dmm_pkg::MAX_RESET, '0, 0);
      queue_op(dmm_pkg::KIND_PUSH_FRONT, dmm_pkg::MIN_RESET, '0, 0);
      queue_op(dmm_pkg::KIND_PUSH_BACK, 0, '0, 0);
      queue_op(dmm_pkg::KIND_PUSH_FRONT, -1, '0, 0);
      queue_op(dmm_pkg::KIND_OVERWRITE, 5, 3, 0);
      queue_op(dmm_pkg::KIND_OVERWRITE, 9, 4, 0);                   // one past the back
      queue_op(dmm_pkg::KIND_OVERWRITE, dmm_pkg::MAX_RESET, 0, 0);  // front now equals the min
      queue_op(dmm_pkg::KIND_POP_FRONT, '0, '0, 0);
      queue_op(dmm_pkg::KIND_POP_FRONT, '0, '0, 0);                 // removes the max
      queue_op(dmm_pkg::KIND_PUSH_BACK, 5, '0, 0);                  // duplicate of the max
      queue_op(dmm_pkg::KIND_POP_BACK, '0, '0, 0);
      queue_op(dmm_pkg::KIND_POP_BACK, '0, '0, 0);
      queue_op(dmm_pkg::KIND_POP_FRONT, '0, '0, 0);                 // becomes empty
      queue_op(dmm_pkg::KIND_PUSH_FRONT, -7, '0, 0);
      queue_op(dmm_pkg::KIND_PUSH_BACK, 7, '0, 0);
      queue_op(dmm_pkg::KIND_POP_BACK, '0, '0, 0);                  // removes the max
      queue_op(dmm_pkg::KIND_POP_FRONT, '0, '0, 0);

      // random: sweep occupancy between empty and full so full pushes, valid
      // overwrites near the top and long rescans all get exercised
      filling = 1'b1;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            if (plan_fill == dmm_pkg::CAPACITY) filling = 1'b0;
            if (plan_fill == 0) filling = 1'b1;
            if (roll < 2) begin
               queue_op(dmm_pkg::KIND_BITS'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                        pick_value(), dmm_pkg::POS_BITS'($urandom_range(63)), ph);
            end else if (roll < 17) begin
               if (plan_fill == 0 || $urandom_range(3) == 0)
                  pos = dmm_pkg::POS_BITS'($urandom_range(63));
               else
                  pos = dmm_pkg::POS_BITS'($urandom_range(plan_fill - 1));
               queue_op(dmm_pkg::KIND_OVERWRITE, pick_value(), pos, ph);
            end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
               queue_op($urandom_range(1) ? dmm_pkg::KIND_PUSH_BACK : dmm_pkg::KIND_PUSH_FRONT,
                        pick_value(), dmm_pkg::POS_BITS'($urandom_range(63)), ph);
            end else begin
               queue_op($urandom_range(1) ? dmm_pkg::KIND_POP_BACK : dmm_pkg::KIND_POP_FRONT,
                        pick_value(), dmm_pkg::POS_BITS'($urandom_range(63)), ph);
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (ops_taken != ops_queued) @(posedge clock);
      while (reply_backlog.size() != 0) @(posedge clock);
      repeat (2 * dmm_pkg::CAPACITY) @(posedge clock);

      if (errors == 0) begin
         $display("deque_with_min_max_tracking_unit verification clean");
      end else begin
         $display("deque_with_min_max_tracking_unit verification failed");
      end
      $finish;
   end

   // Request driver: predicts on each accepted transfer, then offers the next
   // op unless the current phase says to idle this cycle.
   always @(posedge clock) begin : req_driver
      deque_reply_type rep;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_deque_op(in_flight, rep);
            reply_backlog.push_back(rep);
            ops_taken++;
         end
         if (op_backlog.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct[op_backlog[0].phase]) begin
            in_flight = op_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {{(dmm_pkg::REQ_DATA_BITS - dmm_pkg::VALUE_BITS
                             - dmm_pkg::POS_BITS){1'b0}},
                           in_flight.position, in_flight.value};
            req_tuser  <= in_flight.kind;
            run_phase  <= in_flight.phase;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Compare one reply transfer against the oldest prediction.
   task automatic check_reply();
      deque_reply_type              want;
      dmm_pkg::value_type           got_removed;
      dmm_pkg::value_type           got_low;
      dmm_pkg::value_type           got_high;
      logic [dmm_pkg::CNT_BITS-1:0] got_count;
      got_removed = rsp_tdata[dmm_pkg::VALUE_BITS-1:0];
      got_count   = rsp_tdata[dmm_pkg::VALUE_BITS +: dmm_pkg::CNT_BITS];
      got_low     = rsp_tdata[dmm_pkg::VALUE_BITS + dmm_pkg::CNT_BITS +: dmm_pkg::VALUE_BITS];
      got_high    = rsp_tdata[2 * dmm_pkg::VALUE_BITS + dmm_pkg::CNT_BITS +:
                              dmm_pkg::VALUE_BITS];
      if (reply_backlog.size() == 0) begin
         $error("reply transfer with no request outstanding");
         errors++;
         return;
      end
      want = reply_backlog.pop_front();
      if (rsp_tuser !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_tuser);
         errors++;
      end
      if (got_removed !== want.removed) begin
         $error("removed_value: expected %0d, got %0d", want.removed, got_removed);
         errors++;
      end
      if (got_count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got_count);
         errors++;
      end
      if (got_low !== want.low) begin
         $error("min_value: expected %0d, got %0d", want.low, got_low);
         errors++;
      end
      if (got_high !== want.high) begin
         $error("max_value: expected %0d, got %0d", want.high, got_high);
         errors++;
      end
   endtask

   // Reply monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reply();
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct[run_phase]);
      end
   end

   // Watchdog: too long without a transfer on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $error("no transfer for %0d cycles", QUIET_LIMIT);
            $display("deque_with_min_max_tracking_unit verification failed");
            $finish;
         end
      end
   end

endmodule
